### src/fsip_pkg.sv
// Package: shared constants, types and helpers of the stream integer printer.
`default_nettype none

package fsip_pkg;

  localparam int unsigned CharWidth  = 8;
  localparam int unsigned ArgWidth   = 32;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned CharsWidth = 16;
  localparam int unsigned StackDepth = 10;
  localparam int unsigned DepthWidth = $clog2(StackDepth + 1);

  localparam logic [ArgWidth-1:0]  RecipTen    = 32'hCCCC_CCCD;
  localparam int unsigned          RecipShift  = 35;
  localparam logic [CharWidth-1:0] CharPercent = 8'h25;
  localparam logic [CharWidth-1:0] CharMinus   = 8'h2d;
  localparam logic [CharWidth-1:0] CharConvDec = 8'h64;
  localparam logic [CharWidth-1:0] CharConvHex = 8'h78;

  localparam logic [CharWidth-1:0] DigitChars [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ARM,
    ACT_CHAR,
    ACT_DEC,
    ACT_HEX
  } action_e;

  typedef enum logic [1:0] {
    SEL_CHAR,
    SEL_SIGN,
    SEL_DIGIT
  } emit_sel_e;

  typedef struct packed {
    logic      ready;
    logic      step;
    logic      emit;
    emit_sel_e sel;
    logic      last;
  } fsip_cmd_t;

  typedef struct packed {
    logic    in_xfer;
    action_e action;
    logic    q_zero;
    logic    depth_one;
    logic    neg;
    logic    out_free;
  } fsip_status_t;

  function automatic logic [CharWidth-1:0] digit_char(input logic [3:0] d);
    return DigitChars[d];
  endfunction

endpackage

`default_nettype wire

### src/fsip_in_if.sv
// Interface: format character channel with valid/ready handshake.
`default_nettype none

interface fsip_in_if;
  import fsip_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CharWidth-1:0]  format_char;
  logic [ArgWidth-1:0]   arg_value;
  logic                  is_final;

  modport source (output valid, format_char, arg_value, is_final, input ready);
  modport sink   (input valid, format_char, arg_value, is_final, output ready);
endinterface

`default_nettype wire

### src/fsip_out_if.sv
// Interface: emitted character channel with valid/ready handshake.
`default_nettype none

interface fsip_out_if;
  import fsip_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CharWidth-1:0]   out_char;
  logic                   last_of_run;
  logic [CharsWidth-1:0]  chars_written;

  modport source (output valid, out_char, last_of_run, chars_written, input ready);
  modport sink   (input valid, out_char, last_of_run, chars_written, output ready);
endinterface

`default_nettype wire

### src/fsip_datapath.sv
// Datapath: format decode, digit extraction, digit stack, count and output register.
`default_nettype none

module fsip_datapath (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  fsip_in_if.sink               in_i,
  fsip_out_if.source            out_o,
  input  fsip_pkg::fsip_cmd_t    cmd_i,
  output fsip_pkg::fsip_status_t status_o
);
  import fsip_pkg::*;

  logic                  pending_q, pending_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic [DepthWidth-1:0] depth_q, depth_d;
  logic [ArgWidth-1:0]   mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic                  hex_q, hex_d;
  logic [CharWidth-1:0]  char_q, char_d;
  logic [3:0]            stk_q [StackDepth];
  logic [3:0]            stk_d [StackDepth];

  logic                  out_valid_q, out_valid_d;
  logic [CharWidth-1:0]  out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;
  logic [CharsWidth-1:0] out_chars_q, out_chars_d;

  logic                  in_xfer;
  action_e               action;
  logic [63:0]           prod;
  logic [ArgWidth-1:0]   quot_dec, quot_sel, times10, rem_full;
  logic [3:0]            rem_sel;
  logic [CharWidth-1:0]  emit_char;

  assign in_i.ready = cmd_i.ready;
  assign in_xfer    = in_i.valid & in_i.ready;

  always_comb begin
    if (pending_q) begin
      if (in_i.format_char == CharConvDec) begin
        action = ACT_DEC;
      end else if (in_i.format_char == CharConvHex) begin
        action = ACT_HEX;
      end else if (in_i.format_char == CharPercent) begin
        action = ACT_CHAR;
      end else begin
        action = ACT_NONE;
      end
    end else if ((in_i.format_char == CharPercent) && !in_i.is_final) begin
      action = ACT_ARM;
    end else begin
      action = ACT_CHAR;
    end
  end

  // divide by ten via reciprocal multiply; hex divides by sixteen with a shift instead
  assign prod     = {32'b0, mag_q} * {32'b0, RecipTen};
  assign quot_dec = ArgWidth'(prod[63:RecipShift]);
  assign times10  = {quot_dec[ArgWidth-4:0], 3'b000} + {quot_dec[ArgWidth-2:0], 1'b0};
  assign rem_full = mag_q - times10;
  assign quot_sel = hex_q ? {4'b0000, mag_q[ArgWidth-1:4]} : quot_dec;
  assign rem_sel  = hex_q ? mag_q[3:0] : rem_full[3:0];

  always_comb begin
    pending_d = pending_q;
    char_d    = char_q;
    neg_d     = neg_q;
    hex_d     = hex_q;
    mag_d     = mag_q;
    stk_d     = stk_q;
    depth_d   = depth_q;
    if (in_xfer) begin
      pending_d = (action == ACT_ARM);
      char_d    = in_i.format_char;
      neg_d     = (action == ACT_DEC) & in_i.arg_value[ArgWidth-1];
      hex_d     = (action == ACT_HEX);
      mag_d     = ((action == ACT_DEC) && in_i.arg_value[ArgWidth-1]) ?
                  (~in_i.arg_value + ArgWidth'(1)) : in_i.arg_value;
      depth_d   = '0;
    end else if (cmd_i.step) begin
      mag_d    = quot_sel;
      stk_d[0] = rem_sel;
      for (int i = 1; i < StackDepth; i++) begin
        stk_d[i] = stk_q[i-1];
      end
      depth_d = depth_q + DepthWidth'(1);
    end else if (cmd_i.emit && (cmd_i.sel == SEL_DIGIT)) begin
      for (int i = 0; i < StackDepth - 1; i++) begin
        stk_d[i] = stk_q[i+1];
      end
      depth_d = depth_q - DepthWidth'(1);
    end
  end

  always_comb begin
    case (cmd_i.sel)
      SEL_CHAR:  emit_char = char_q;
      SEL_SIGN:  emit_char = CharMinus;
      SEL_DIGIT: emit_char = digit_char(stk_q[0]);
      default:   emit_char = char_q;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_chars_d = out_chars_q;
    if (cmd_i.emit) begin
      count_d     = (count_q != {CountWidth{1'b1}}) ? count_q + CountWidth'(1) : count_q;
      out_valid_d = 1'b1;
      out_char_d  = emit_char;
      out_last_d  = cmd_i.last;
      out_chars_d = CharsWidth'(count_d);
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 1'b0;
      count_q     <= '0;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pending_q   <= pending_d;
      count_q     <= count_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    neg_q       <= neg_d;
    hex_q       <= hex_d;
    char_q      <= char_d;
    stk_q       <= stk_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
    out_chars_q <= out_chars_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_char      = out_char_q;
  assign out_o.last_of_run   = out_last_q;
  assign out_o.chars_written = out_chars_q;

  assign status_o.in_xfer   = in_xfer;
  assign status_o.action    = action;
  assign status_o.q_zero    = (quot_sel == '0);
  assign status_o.depth_one = (depth_q == DepthWidth'(1));
  assign status_o.neg       = neg_q;
  assign status_o.out_free  = !out_valid_q || out_o.ready;

endmodule

`default_nettype wire

### src/fsip_ctrl.sv
// Controller: sequences accept, digit extraction and character emission.
`default_nettype none

module fsip_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  fsip_pkg::fsip_status_t status_i,
  output fsip_pkg::fsip_cmd_t    cmd_o
);
  import fsip_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ONE,
    S_CONV,
    S_SIGN,
    S_DIG
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o.ready = 1'b0;
    cmd_o.step  = 1'b0;
    cmd_o.emit  = 1'b0;
    cmd_o.sel   = SEL_CHAR;
    cmd_o.last  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.ready = 1'b1;
        if (status_i.in_xfer) begin
          unique case (status_i.action)
            ACT_CHAR:         state_d = S_ONE;
            ACT_DEC, ACT_HEX: state_d = S_CONV;
            default:          state_d = S_IDLE;
          endcase
        end
      end
      S_ONE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_CONV: begin
        cmd_o.step = 1'b1;
        if (status_i.q_zero) begin
          state_d = status_i.neg ? S_SIGN : S_DIG;
        end
      end
      S_SIGN: begin
        cmd_o.sel  = SEL_SIGN;
        cmd_o.last = 1'b0;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_DIG;
        end
      end
      S_DIG: begin
        cmd_o.sel  = SEL_DIGIT;
        cmd_o.last = status_i.depth_one;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.depth_one) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### src/format_stream_int_printer.sv
// Top level: streaming printf formatter for %d, %x and %% conversions.
// An echoed byte is latched on transfer and sent to the output register from S_ONE
// once the output is free. A %d or %x pushes digits onto the stack in S_CONV (a
// reciprocal divide by ten for %d, a 4-bit shift for %x), then emits up to 11 chars
// via S_SIGN and S_DIG. One item at a time; a new item is taken once the last char
// is registered. Reset clears the pending flag, saturating count and output valid.
`default_nettype none

module format_stream_int_printer (
  input  wire         clk_i,
  input  wire         rst_ni,
  fsip_in_if.sink     in_i,
  fsip_out_if.source  out_o
);
  import fsip_pkg::*;

  fsip_cmd_t    cmd;
  fsip_status_t status;

  fsip_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  fsip_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .cmd_i    (cmd),
    .status_o (status)
  );

  // a run continues without gaps once its first character is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.last_of_run |=> out_o.valid)
    else $error("character run broken");

  // no new item while a run is unfinished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !(out_o.valid && !out_o.last_of_run))
    else $error("input taken mid run");

  // extraction never overlaps an emit or an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> !(cmd.emit || cmd.ready))
    else $error("extraction overlaps emit or accept");

endmodule

`default_nettype wire
